// ===== hdl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// RPC header classifier package
// Shared types and constants for the header tracker, verdict logic and top.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

    // marks found in payload byte 0
    localparam logic [7:0] STRICT_MARK  = 8'h80;
    localparam logic [7:0] COMPACT_MARK = 8'h82;

    // header limits
    localparam logic [7:0]  VERSION_MAX       = 8'h01;
    localparam logic [7:0]  KIND_LIMIT        = 8'd5;
    localparam logic [15:0] STRICT_HDR_BYTES  = 16'd8;
    localparam logic [15:0] COMPACT_HDR_BYTES = 16'd6;
    localparam logic [15:0] OFFSET_MAX        = 16'hFFFF;

    // printable method name bytes
    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7E;

    // message kinds that raise a risk flag
    localparam logic [7:0] KIND_INVALID   = 8'd0;
    localparam logic [7:0] KIND_EXCEPTION = 8'd3;

    // header form named by byte 0
    typedef enum logic [1:0] {
        FORM_NONE    = 2'd0,
        FORM_STRICT  = 2'd1,
        FORM_COMPACT = 2'd2
    } form_t;

    // header fields gathered over one packet
    typedef struct packed {
        form_t       form;
        logic [7:0]  version;
        logic [7:0]  kind;
        logic [31:0] name_len;
        logic        all_printable;
    } hdr_state_t;

    // classification of one packet
    typedef struct packed {
        logic        detected;
        logic [1:0]  variant;
        logic [2:0]  message_kind;
        logic [15:0] name_length;
        logic        name_unprintable;
        logic        malformed_risk;
        logic        exception_risk;
    } verdict_t;

endpackage

`default_nettype wire

// ===== hdl/rhc_tracker.sv =====
// ----------------------------------------------------------------------------
// RPC header tracker
// Follows the byte offset and collects header fields and the printable flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_tracker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                strobe,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last_byte,
    output rhc_pkg::hdr_state_t      snap
);
    import rhc_pkg::*;

    logic [15:0] offset_reg;
    logic [15:0] offset_next;
    hdr_state_t  state_reg;
    hdr_state_t  state_next;
    hdr_state_t  clear_value;
    logic [15:0] hdr_bytes;
    logic        has_form;
    logic        in_name;
    logic        unprintable;

    assign clear_value = '{form: FORM_NONE, version: 8'd0, kind: 8'd0,
                           name_len: 32'd0, all_printable: 1'b1};

    assign unprintable = (data_byte < PRINT_LOW) || (data_byte > PRINT_HIGH);

    // header view including the byte in hand
    always_comb
    begin
        snap      = state_reg;
        hdr_bytes = 16'd0;
        has_form  = 1'b0;
        if (offset_reg == 16'd0)
        begin
            if (data_byte == STRICT_MARK)
                snap.form = FORM_STRICT;
            else if (data_byte == COMPACT_MARK)
                snap.form = FORM_COMPACT;
            else
                snap.form = FORM_NONE;
        end
        else
        begin
            unique case (state_reg.form)
                FORM_STRICT:
                begin
                    has_form  = 1'b1;
                    hdr_bytes = STRICT_HDR_BYTES;
                    if (offset_reg == 16'd1)
                        snap.version = data_byte;
                    else if (offset_reg == 16'd3)
                        snap.kind = data_byte;
                    else if (offset_reg >= 16'd4 && offset_reg <= 16'd7)
                        snap.name_len = {state_reg.name_len[23:0], data_byte};
                end
                FORM_COMPACT:
                begin
                    has_form  = 1'b1;
                    hdr_bytes = COMPACT_HDR_BYTES;
                    if (offset_reg == 16'd1)
                    begin
                        snap.version = {3'd0, data_byte[4:0]};
                        snap.kind    = {5'd0, data_byte[7:5]};
                    end
                    else if (offset_reg == 16'd5)
                        snap.name_len = {24'd0, data_byte};
                end
                default:
                begin
                    has_form = 1'b0;
                end
            endcase
        end
        // method name bytes are checked for printability
        in_name = has_form && (offset_reg >= hdr_bytes)
                  && ({16'd0, offset_reg - hdr_bytes} < snap.name_len);
        if (in_name && unprintable)
            snap.all_printable = 1'b0;
    end

    // next state: advance on a byte, clear after the last one
    always_comb
    begin
        offset_next = offset_reg;
        state_next  = state_reg;
        if (strobe)
        begin
            if (last_byte)
            begin
                offset_next = 16'd0;
                state_next  = clear_value;
            end
            else
            begin
                state_next = snap;
                if (offset_reg != OFFSET_MAX)
                    offset_next = offset_reg + 16'd1;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 16'd0;
            state_reg  <= '{form: FORM_NONE, version: 8'd0, kind: 8'd0,
                            name_len: 32'd0, all_printable: 1'b1};
        end
        else
        begin
            offset_reg <= offset_next;
            state_reg  <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rhc_verdict.sv =====
// ----------------------------------------------------------------------------
// RPC header verdict
// Decides acceptance of the collected header and forms the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_verdict (
    input  wire rhc_pkg::hdr_state_t snap,
    input  wire logic [15:0]         payload_length,
    input  wire logic                over_udp,
    output rhc_pkg::verdict_t        verdict
);
    import rhc_pkg::*;

    logic [15:0] hdr_bytes;
    logic        form_ok;
    logic        fits;
    logic        ok;

    // transport and minimum length per form
    always_comb
    begin
        hdr_bytes = 16'd0;
        form_ok   = 1'b0;
        if (payload_length >= COMPACT_HDR_BYTES)
        begin
            unique case (snap.form)
                FORM_STRICT:
                begin
                    hdr_bytes = STRICT_HDR_BYTES;
                    form_ok   = !over_udp && (payload_length >= STRICT_HDR_BYTES);
                end
                FORM_COMPACT:
                begin
                    hdr_bytes = COMPACT_HDR_BYTES;
                    form_ok   = over_udp;
                end
                default:
                begin
                    form_ok = 1'b0;
                end
            endcase
        end
    end

    // header plus method name must fit in the payload
    assign fits = (snap.name_len[31:16] == 16'd0)
                  && (({1'b0, snap.name_len[15:0]} + {1'b0, hdr_bytes})
                      <= {1'b0, payload_length});

    assign ok = form_ok && fits && (snap.version <= VERSION_MAX)
                && (snap.kind < KIND_LIMIT);

    // result fields
    always_comb
    begin
        verdict.detected         = ok;
        verdict.variant          = snap.form;
        verdict.message_kind     = ok ? snap.kind[2:0] : 3'd0;
        verdict.name_length      = ok ? snap.name_len[15:0] : 16'd0;
        verdict.name_unprintable = ok && !snap.all_printable;
        verdict.malformed_risk   = ok && (snap.kind == KIND_INVALID);
        verdict.exception_risk   = ok && (snap.kind == KIND_EXCEPTION);
    end

endmodule

`default_nettype wire

// ===== hdl/rpc_header_classifier.sv =====
// ----------------------------------------------------------------------------
// RPC header classifier
// Streams payload bytes and classifies each packet as an RPC message header.
// ----------------------------------------------------------------------------
// One payload byte is taken per cycle. Each byte lands in an input register,
// passes once through the header tracker and verdict logic, and the byte that
// carries last_byte loads the result register as it leaves the input register
// and raises out_valid. The input stalls only while the input register holds
// the last byte of a packet and an earlier result sits in the result register
// unread; the byte behind it waits as well.
// No result is produced for other bytes.
`default_nettype none

module rpc_header_classifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] payload_length,
    input  wire logic        over_udp,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             detected,
    output logic [1:0]       variant,
    output logic [2:0]       message_kind,
    output logic [15:0]      name_length,
    output logic             name_unprintable,
    output logic             malformed_risk,
    output logic             exception_risk
);
    import rhc_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  byte_reg;
    logic [15:0] plen_reg;
    logic        udp_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    verdict_t    result_reg;
    hdr_state_t  snap;
    verdict_t    verdict;
    logic        advance;
    logic        in_xfer;

    // the held byte moves on unless it ends a packet and the result is blocked
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    assign in_valid_next  = in_xfer || (in_valid_reg && !advance);
    assign out_valid_next = (advance && last_reg) || (out_valid_reg && !out_ready);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= data_byte;
            plen_reg <= payload_length;
            udp_reg  <= over_udp;
            last_reg <= last_byte;
        end
    end

    rhc_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .strobe    (advance),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .snap      (snap)
    );

    rhc_verdict u_verdict (
        .snap           (snap),
        .payload_length (plen_reg),
        .over_udp       (udp_reg),
        .verdict        (verdict)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
            result_reg <= verdict;
    end

    assign out_valid        = out_valid_reg;
    assign detected         = result_reg.detected;
    assign variant          = result_reg.variant;
    assign message_kind     = result_reg.message_kind;
    assign name_length      = result_reg.name_length;
    assign name_unprintable = result_reg.name_unprintable;
    assign malformed_risk   = result_reg.malformed_risk;
    assign exception_risk   = result_reg.exception_risk;

    // an accepted header always names a form
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && detected |-> (variant != 2'd0))
        else $error("detected result without a header form");

    // a rejected packet reports no header fields but the variant, and no risks
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !detected |-> (message_kind == 3'd0) && (name_length == 16'd0)
            && !name_unprintable && !malformed_risk && !exception_risk)
        else $error("rejected result carries header fields");

    // the two risk flags exclude each other
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(malformed_risk && exception_risk))
        else $error("malformed and exception risk both set");

    // a last byte blocked by an unread result stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && last_reg && out_valid_reg && !out_ready
            |=> in_valid_reg && last_reg && out_valid_reg)
        else $error("last byte lost while result stalled");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// RPC header classifier testbench
// Streams packets byte by byte into the classifier and checks each verdict
// against a predictor of the header tracking rules.
// ----------------------------------------------------------------------------
// Directed packets cover both header forms, the risk flags, a packet that
// ends early and the shortest packets. Random packets are mostly well-formed
// headers with random content, mixed with noise and broken packets. Both
// sides idle in random bursts, and the last phase runs with no idling.
`timescale 1ns / 1ps

module tb_top;

    import rhc_pkg::*;

    typedef bit [7:0] byte_q_t[$];

    // predictor and store of expected verdicts
    class rpc_scoreboard;
        bit [15:0]   offset;
        form_t       form;
        bit [7:0]    version;
        bit [7:0]    kind;
        bit [31:0]   name_len;
        bit          printable;
        verdict_t    verdict_q[$];
        int unsigned errors;
        int unsigned packets;
        int unsigned detections;

        function new();
            errors     = 0;
            packets    = 0;
            detections = 0;
            clear_header();
        endfunction

        function void clear_header();
            offset    = '0;
            form      = FORM_NONE;
            version   = '0;
            kind      = '0;
            name_len  = '0;
            printable = 1'b1;
        endfunction

        function int unsigned pending();
            return verdict_q.size();
        endfunction

        // track one accepted byte; the last byte of a packet yields a verdict
        function void note_byte(bit [7:0] b, bit [15:0] plen, bit udp, bit last);
            bit [15:0] hdr_bytes;
            bit        ok;
            verdict_t  v;

            hdr_bytes = '0;
            if (offset == 16'd0)
            begin
                if (b == STRICT_MARK)
                    form = FORM_STRICT;
                else if (b == COMPACT_MARK)
                    form = FORM_COMPACT;
                else
                    form = FORM_NONE;
            end
            else if (form != FORM_NONE)
            begin
                if (form == FORM_STRICT)
                begin
                    hdr_bytes = STRICT_HDR_BYTES;
                    if (offset == 16'd1)
                        version = b;
                    else if (offset == 16'd3)
                        kind = b;
                    else if (offset >= 16'd4 && offset <= 16'd7)
                        name_len = {name_len[23:0], b};
                end
                else
                begin
                    hdr_bytes = COMPACT_HDR_BYTES;
                    if (offset == 16'd1)
                    begin
                        version = {3'b000, b[4:0]};
                        kind    = {5'b00000, b[7:5]};
                    end
                    else if (offset == 16'd5)
                        name_len = {24'd0, b};
                end
                // method name bytes must be printable
                if (offset >= hdr_bytes && 32'(offset - hdr_bytes) < name_len
                    && (b < PRINT_LOW || b > PRINT_HIGH))
                    printable = 1'b0;
            end
            if (offset != OFFSET_MAX)
                offset++;
            if (!last)
                return;

            // verdict at the end of the packet
            ok        = 1'b0;
            hdr_bytes = '0;
            if (plen >= COMPACT_HDR_BYTES)
            begin
                if (form == FORM_STRICT)
                begin
                    hdr_bytes = STRICT_HDR_BYTES;
                    ok        = !udp && plen >= STRICT_HDR_BYTES;
                end
                else if (form == FORM_COMPACT)
                begin
                    hdr_bytes = COMPACT_HDR_BYTES;
                    ok        = udp;
                end
            end
            if (ok && {17'd0, plen} < {17'd0, hdr_bytes} + {1'b0, name_len})
                ok = 1'b0;
            if (ok && version > VERSION_MAX)
                ok = 1'b0;
            if (ok && kind >= KIND_LIMIT)
                ok = 1'b0;

            v.detected         = ok;
            v.variant          = form;
            v.message_kind     = ok ? kind[2:0] : 3'd0;
            v.name_length      = ok ? name_len[15:0] : 16'd0;
            v.name_unprintable = ok && !printable;
            v.malformed_risk   = ok && kind == KIND_INVALID;
            v.exception_risk   = ok && kind == KIND_EXCEPTION;
            verdict_q.push_back(v);
            packets++;
            if (ok)
                detections++;
            clear_header();
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // compare one result transfer with the oldest expected verdict
        function void check_result(verdict_t got);
            verdict_t want;

            if (verdict_q.size() == 0)
            begin
                $error("result transfer with no packet outstanding");
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            compare("detected", 32'(want.detected), 32'(got.detected));
            compare("variant", 32'(want.variant), 32'(got.variant));
            compare("message_kind", 32'(want.message_kind), 32'(got.message_kind));
            compare("name_length", 32'(want.name_length), 32'(got.name_length));
            compare("name_unprintable", 32'(want.name_unprintable),
                    32'(got.name_unprintable));
            compare("malformed_risk", 32'(want.malformed_risk), 32'(got.malformed_risk));
            compare("exception_risk", 32'(want.exception_risk), 32'(got.exception_risk));
        endfunction
    endclass

    localparam int unsigned RANDOM_BYTES = 1630;
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned TAIL_CYCLES  = 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic [15:0] payload_length;
    logic        over_udp;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic        detected;
    logic [1:0]  variant;
    logic [2:0]  message_kind;
    logic [15:0] name_length;
    logic        name_unprintable;
    logic        malformed_risk;
    logic        exception_risk;

    rpc_scoreboard sb;
    bit            send_gaps;
    bit            recv_gaps;
    int unsigned   bytes_sent;
    int unsigned   quiet_cycles;

    rpc_header_classifier u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .payload_length   (payload_length),
        .over_udp         (over_udp),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .detected         (detected),
        .variant          (variant),
        .message_kind     (message_kind),
        .name_length      (name_length),
        .name_unprintable (name_unprintable),
        .malformed_risk   (malformed_risk),
        .exception_risk   (exception_risk)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // transfer monitor: predict on input, check on output
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_byte(data_byte, payload_length, over_udp, last_byte);
        if (rst_n && out_valid && out_ready)
            sb.check_result({detected, variant, message_kind, name_length,
                             name_unprintable, malformed_risk, exception_risk});
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side with random stall bursts
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (recv_gaps && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // one byte transfer, with an optional idle burst ahead of it
    task automatic send_byte(input bit [7:0] b, input bit [15:0] plen,
                             input bit udp, input bit last);
        if (send_gaps && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        payload_length <= plen;
        over_udp       <= udp;
        last_byte      <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet(input byte_q_t pb, input bit [15:0] plen, input bit udp);
        foreach (pb[i])
            send_byte(pb[i], plen, udp, i == pb.size() - 1);
    endtask

    // stop sending until every verdict has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // mostly well-formed headers with random content, some noise
    task automatic random_packet();
        byte_q_t     pb;
        int unsigned sel;
        int unsigned nlen;
        int unsigned cut;
        bit [7:0]    ver;
        bit [7:0]    kind;
        bit [31:0]   len_field;
        bit [15:0]   plen;
        bit          udp;

        sel  = $urandom_range(0, 99);
        nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
        ver  = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 1));
        kind = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 4));
        if (sel < 40)
        begin
            // strict binary form
            len_field = ($urandom_range(0, 15) == 0) ? $urandom() : nlen;
            pb = '{STRICT_MARK, ver, 8'($urandom()), kind,
                   len_field[31:24], len_field[23:16], len_field[15:8], len_field[7:0]};
            udp = ($urandom_range(0, 9) == 0);
        end
        else if (sel < 80)
        begin
            // compact form
            if (nlen > 255)
                nlen = 255;
            if ($urandom_range(0, 3) == 0)
                kind = 8'($urandom_range(0, 7));
            pb = '{COMPACT_MARK, {kind[2:0], ver[4:0]}, 8'($urandom()),
                   8'($urandom()), 8'($urandom()), 8'(nlen)};
            udp = ($urandom_range(0, 9) != 0);
        end
        else
        begin
            // noise
            nlen = 0;
            repeat ($urandom_range(1, 10))
                pb.push_back(8'($urandom()));
            udp = 1'($urandom_range(0, 1));
        end

        // method name, mostly printable
        repeat (nlen)
            pb.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom())
                                                      : 8'($urandom_range(8'h20, 8'h7E)));
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
            pb.push_back(8'($urandom()));

        // payload length mostly matches, sometimes short or arbitrary
        plen = 16'(pb.size());
        if ($urandom_range(0, 7) == 0 && pb.size() > 3)
            plen = 16'(pb.size() - $urandom_range(1, 3));
        else if ($urandom_range(0, 11) == 0)
            plen = 16'($urandom_range(1, 65535));

        // packet that ends early
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(0, pb.size() - 1);
            pb  = pb[0:cut];
        end
        send_packet(pb, plen, udp);
    endtask

    // directed packets, then random phases
    initial
    begin
        int unsigned phase;

        sb             = new();
        bytes_sent     = 0;
        send_gaps      = 1'b0;
        recv_gaps      = 1'b0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        data_byte      <= '0;
        payload_length <= '0;
        over_udp       <= 1'b0;
        last_byte      <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // strict header, version 1, exception type, empty method name
        send_packet('{8'h80, 8'h01, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00}, 16'd8, 1'b0);
        // compact header, type zero, unprintable one-byte method name
        send_packet('{8'h82, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7F}, 16'd7, 1'b1);
        // single byte packets at both length extremes
        send_packet('{8'hFF}, 16'hFFFF, 1'b1);
        send_packet('{8'h00}, 16'd1, 1'b0);
        // strict header ending early in a short packet
        send_packet('{8'h80, 8'h01, 8'hFF}, 16'd3, 1'b0);
        // compact header ending after the type byte
        send_packet('{8'h82, 8'h21}, 16'd6, 1'b1);
        wait_for_results();

        for (phase = 0; phase < 4; phase++)
        begin
            send_gaps = (phase == 0 || phase == 1);
            recv_gaps = (phase == 0 || phase == 2);
            while (bytes_sent < 22 + (phase + 1) * RANDOM_BYTES / 4)
                random_packet();
            wait_for_results();
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d packets in %0d bytes, %0d classified as rpc headers",
                 sb.packets, bytes_sent, sb.detections);
        $display("both header forms, noise, early ends, idle bursts and full drains");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
